// File: design/teq_pkg.sv
// Package for the three-band equalizer core: fixed widths, register indexes,
// and the pole saturation function. No dependencies.
package teq_pkg;

    // Configuration register map
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 18;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_COEFF  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_COEFF = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MID_GAIN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_GAIN  = 3'd4;

    localparam int COEFF_BITS = 18;
    localparam int GAIN_BITS  = 16;
    localparam logic [COEFF_BITS-1:0] LOW_COEFF_RST  = 18'd3431;
    localparam logic [COEFF_BITS-1:0] HIGH_COEFF_RST = 18'd32920;
    localparam logic [GAIN_BITS-1:0]  GAIN_RST       = 16'd8192;

    // Filter structure
    localparam int STAGES     = 4;
    localparam int STAGE_BITS = 2;
    localparam int DELAY_TAPS = 3;
    localparam int POLE_BITS  = 24;   // Q8.16
    localparam int X_BITS     = 17;   // input sample in Q1.16

    // Digit-serial multiplier
    localparam int DIGIT_BITS  = 6;
    localparam int MUL_DIGITS  = 3;
    localparam int DCNT_BITS   = 2;
    localparam int MPLIER_BITS = DIGIT_BITS * MUL_DIGITS;
    localparam int MCAND_BITS  = 25;
    localparam int PART_BITS   = MCAND_BITS + DIGIT_BITS + 1;
    localparam int ACC_BITS    = PART_BITS - DIGIT_BITS;
    localparam int PROD_BITS   = ACC_BITS + MPLIER_BITS;

    // Pole update: p + round(prod / 2^16)
    localparam int RND_SHIFT = 16;
    localparam int NP_BITS   = PROD_BITS - RND_SHIFT + 1;

    function automatic logic [POLE_BITS-1:0] sat_pole(input logic [NP_BITS-1:0] v);
        logic neg;
        logic hi_ones;
        logic hi_zeros;
        neg      = v[NP_BITS-1];
        hi_ones  = &v[NP_BITS-1:POLE_BITS-1];
        hi_zeros = ~|v[NP_BITS-1:POLE_BITS-1];
        if (!neg && !hi_zeros)
        begin
            sat_pole = {1'b0, {(POLE_BITS-1){1'b1}}};
        end
        else if (neg && !hi_ones)
        begin
            sat_pole = {1'b1, {(POLE_BITS-1){1'b0}}};
        end
        else
        begin
            sat_pole = v[POLE_BITS-1:0];
        end
    endfunction

endpackage

// File: design/teq_dmul.sv
// Digit-serial signed x unsigned multiplier, LSB digit first.
// Depends on teq_pkg for operand and product widths.
module teq_dmul (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [teq_pkg::MCAND_BITS-1:0]  mcand,
    input  logic        [teq_pkg::MPLIER_BITS-1:0] mplier,
    output logic signed [teq_pkg::PROD_BITS-1:0]   product,
    output logic                                   done
);
    localparam int MC = teq_pkg::MCAND_BITS;
    localparam int ML = teq_pkg::MPLIER_BITS;
    localparam int DG = teq_pkg::DIGIT_BITS;
    localparam int PT = teq_pkg::PART_BITS;
    localparam int AC = teq_pkg::ACC_BITS;
    localparam int CB = teq_pkg::DCNT_BITS;
    localparam logic [CB-1:0] LAST_DIGIT = CB'(teq_pkg::MUL_DIGITS - 1);

    logic signed [MC-1:0] mcand_reg;
    logic        [ML-1:0] mpl_reg;
    logic signed [AC-1:0] acc_reg;
    logic        [ML-1:0] lo_reg;
    logic        [CB-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic signed [PT-1:0] part;
    logic signed [PT-1:0] psum;

    always_comb
    begin
        part = PT'(mcand_reg) * PT'($signed({1'b0, mpl_reg[DG-1:0]}));
        psum = PT'(acc_reg) + part;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_DIGIT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Low product bits shift out of the accumulator into lo_reg
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            mpl_reg   <= mplier;
            acc_reg   <= '0;
            lo_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= psum[PT-1:DG];
            lo_reg  <= {psum[DG-1:0], lo_reg[ML-1:DG]};
            mpl_reg <= mpl_reg >> DG;
        end
    end

    assign product = {acc_reg, lo_reg};
    assign done    = done_reg;

endmodule

// File: design/three_band_equalizer_core.sv
// Three-band equalizer core: two four-pole cascades, band gains, saturation.
// Depends on teq_pkg and teq_dmul.
//
// Channel | Handshake            | Payload
// in      | in_valid / in_stall  | sample_in, channel_index
// out     | out_valid / out_stall| sample_out, channel_out
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item passes through the idle state that takes it, four pole stages on two 6-bit
// digit-serial multipliers (low and high cascade side by side), a gain load step, two
// gain passes on the same units, then a rounding step. An item on an unknown channel
// goes straight to the rounding step. The result is registered as the rounding step
// completes; the next item is taken the cycle after, while that result may still wait
// at the output.
// A stalled result holds the block in its last cycle until the output register frees.
// Reset clears filter state at once through per-entry valid bits; cfg_ready is always high.
module three_band_equalizer_core #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [SAMPLE_BITS-1:0]             sample_in,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] channel_index,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [SAMPLE_BITS-1:0]             sample_out,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] channel_out,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [teq_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [teq_pkg::CFG_DATA_BITS-1:0]         cfg_data
);
    localparam int CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NPOLE    = CHANNELS * teq_pkg::STAGES;
    localparam int PA_BITS  = $clog2(NPOLE);
    localparam int SB       = SAMPLE_BITS;
    localparam int ROW_BITS = teq_pkg::DELAY_TAPS * SB;
    localparam int PB       = teq_pkg::POLE_BITS;
    localparam int XB       = teq_pkg::X_BITS;
    localparam int MC       = teq_pkg::MCAND_BITS;
    localparam int ML       = teq_pkg::MPLIER_BITS;
    localparam int PRW      = teq_pkg::PROD_BITS;
    localparam int NPW      = teq_pkg::NP_BITS;
    localparam int RS       = teq_pkg::RND_SHIFT;
    localparam int SGB      = teq_pkg::STAGE_BITS;
    localparam int CB       = teq_pkg::COEFF_BITS;
    localparam int GB       = teq_pkg::GAIN_BITS;
    localparam logic [SGB-1:0] LAST_STAGE = SGB'(teq_pkg::STAGES - 1);

    // Sample to Q8.16
    localparam int X_UP = (SB <= XB) ? XB - SB : 0;
    localparam int X_DN = (SB > XB) ? SB - XB : 0;
    localparam int XW   = SB + X_UP;

    // Q.29 sum to output format
    localparam int RSH  = (SB <= 30) ? 30 - SB : 0;
    localparam int LSH  = (SB > 30) ? SB - 30 : 0;
    localparam int HALF = (RSH > 0) ? (1 << (RSH - 1)) : 0;
    localparam int RW   = PRW + 1 + LSH;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_GAIN = 7'b0001000,
        S_GMUL = 7'b0010000,
        S_MID  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CB-1:0] low_coeff_reg, high_coeff_reg;
    logic [GB-1:0] low_gain_reg, mid_gain_reg, high_gain_reg;

    logic signed [SB-1:0]  smp_reg;
    logic [CH_BITS-1:0]    ch_reg;
    logic                  bad_reg;
    logic [SGB-1:0]        stage_reg;
    logic signed [PB-1:0]  xl_reg, xh_reg;
    logic signed [PRW-1:0] sum_reg;

    logic [2*PB-1:0]     pole_mem [NPOLE];
    logic [NPOLE-1:0]    pole_vld_reg;
    logic [2*PB-1:0]     pole_rd_reg;
    logic                pole_rdv_reg;
    logic [ROW_BITS-1:0] dly_mem [CHANNELS];
    logic [CHANNELS-1:0] dly_vld_reg;
    logic [ROW_BITS-1:0] dly_rd_reg;
    logic                dly_rdv_reg;

    logic                  out_valid_reg;
    logic signed [SB-1:0]  sample_out_reg;
    logic [CH_BITS-1:0]    channel_out_reg;

    logic                  in_acc, out_free, ch_ok_in;
    logic                  start_a, start_b;
    logic signed [MC-1:0]  mcand_a, mcand_b;
    logic [ML-1:0]         mpl_a, mpl_b;
    logic signed [PRW-1:0] prod_a, prod_b;
    logic                  done_a, done_b;
    logic                  pole_rd_en, pole_we, dly_rd_en, dly_we;
    logic [PA_BITS-1:0]    pole_raddr, pole_waddr;

    logic signed [XW-1:0]  x_wide, d_wide;
    logic signed [XB-1:0]  x_in, d_x;
    logic [ROW_BITS-1:0]   dly_cur;
    logic signed [PB-1:0]  pl, ph;
    logic signed [NPW-1:0] np_a, np_b;
    logic [PB-1:0]         npl, nph;
    logic signed [RW-1:0]  rsum, rshift;
    logic signed [SB-1:0]  res;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign ch_ok_in = {1'b0, channel_index} < (CH_BITS + 1)'(CHANNELS);

    // Datapath helpers
    always_comb
    begin
        x_wide  = XW'(sample_in) <<< X_UP;
        x_in    = XB'(x_wide >>> X_DN);
        dly_cur = dly_rdv_reg ? dly_rd_reg : '0;
        d_wide  = XW'($signed(dly_cur[ROW_BITS-1:ROW_BITS-SB])) <<< X_UP;
        d_x     = XB'(d_wide >>> X_DN);
        pl      = pole_rdv_reg ? pole_rd_reg[2*PB-1:PB] : '0;
        ph      = pole_rdv_reg ? pole_rd_reg[PB-1:0] : '0;
        // round half up: floor(prod / 2^16) plus bit 15
        np_a    = NPW'(pl) + NPW'($signed(prod_a[PRW-1:RS])) + NPW'({1'b0, prod_a[RS-1]});
        np_b    = NPW'(ph) + NPW'($signed(prod_b[PRW-1:RS])) + NPW'({1'b0, prod_b[RS-1]});
        npl     = teq_pkg::sat_pole(np_a);
        nph     = teq_pkg::sat_pole(np_b);
        rsum    = RW'(sum_reg) + RW'(HALF);
        rshift  = (rsum <<< LSH) >>> RSH;
        if (!rshift[RW-1] && |rshift[RW-2:SB-1])
        begin
            res = {1'b0, {(SB-1){1'b1}}};
        end
        else if (rshift[RW-1] && !(&rshift[RW-2:SB-1]))
        begin
            res = {1'b1, {(SB-1){1'b0}}};
        end
        else
        begin
            res = rshift[SB-1:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        start_a    = 1'b0;
        start_b    = 1'b0;
        mcand_a    = MC'(xl_reg) - MC'(pl);
        mcand_b    = MC'(xh_reg) - MC'(ph);
        mpl_a      = low_coeff_reg;
        mpl_b      = high_coeff_reg;
        pole_rd_en = 1'b0;
        pole_we    = 1'b0;
        dly_rd_en  = 1'b0;
        dly_we     = 1'b0;
        pole_raddr = PA_BITS'({ch_reg, SGB'(stage_reg + 1'b1)});
        pole_waddr = PA_BITS'({ch_reg, stage_reg});
        case (state_reg)
            S_IDLE:
            begin
                pole_raddr = PA_BITS'({channel_index, SGB'(0)});
                if (in_valid)
                begin
                    pole_rd_en = ch_ok_in;
                    dly_rd_en  = ch_ok_in;
                    state_next = ch_ok_in ? S_LOAD : S_FIN;
                end
            end
            S_LOAD:
            begin
                start_a    = 1'b1;
                start_b    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (done_a && done_b)
                begin
                    pole_we = 1'b1;
                    if (stage_reg == LAST_STAGE)
                    begin
                        state_next = S_GAIN;
                    end
                    else
                    begin
                        pole_rd_en = 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_GAIN:
            begin
                start_a    = 1'b1;
                start_b    = 1'b1;
                mcand_a    = MC'(xl_reg);
                mpl_a      = ML'(low_gain_reg);
                mcand_b    = MC'(d_x) - MC'(xh_reg);
                mpl_b      = ML'(high_gain_reg);
                state_next = S_GMUL;
            end
            S_GMUL:
            begin
                mcand_a = MC'(xh_reg) - MC'(xl_reg);
                mpl_a   = ML'(mid_gain_reg);
                if (done_a && done_b)
                begin
                    start_a    = 1'b1;
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                if (done_a)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    dly_we     = !bad_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    teq_dmul u_mul_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_a),
        .mcand   (mcand_a),
        .mplier  (mpl_a),
        .product (prod_a),
        .done    (done_a)
    );

    teq_dmul u_mul_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_b),
        .mcand   (mcand_b),
        .mplier  (mpl_b),
        .product (prod_b),
        .done    (done_b)
    );

    // Control state, configuration, valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            stage_reg      <= '0;
            bad_reg        <= 1'b0;
            low_coeff_reg  <= teq_pkg::LOW_COEFF_RST;
            high_coeff_reg <= teq_pkg::HIGH_COEFF_RST;
            low_gain_reg   <= teq_pkg::GAIN_RST;
            mid_gain_reg   <= teq_pkg::GAIN_RST;
            high_gain_reg  <= teq_pkg::GAIN_RST;
            pole_vld_reg   <= '0;
            dly_vld_reg    <= '0;
            pole_rdv_reg   <= 1'b0;
            dly_rdv_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                stage_reg <= '0;
                bad_reg   <= !ch_ok_in;
            end
            else if (state_reg == S_MUL && done_a && done_b)
            begin
                stage_reg <= stage_reg + 1'b1;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    teq_pkg::REG_LOW_COEFF:  low_coeff_reg  <= cfg_data;
                    teq_pkg::REG_HIGH_COEFF: high_coeff_reg <= cfg_data;
                    teq_pkg::REG_LOW_GAIN:   low_gain_reg   <= cfg_data[GB-1:0];
                    teq_pkg::REG_MID_GAIN:   mid_gain_reg   <= cfg_data[GB-1:0];
                    teq_pkg::REG_HIGH_GAIN:  high_gain_reg  <= cfg_data[GB-1:0];
                    default: ;
                endcase
            end
            if (pole_we)
            begin
                pole_vld_reg[pole_waddr] <= 1'b1;
            end
            if (pole_rd_en)
            begin
                pole_rdv_reg <= pole_vld_reg[pole_raddr];
            end
            if (dly_we)
            begin
                dly_vld_reg[ch_reg] <= 1'b1;
            end
            if (dly_rd_en)
            begin
                dly_rdv_reg <= dly_vld_reg[channel_index];
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Filter state memories
    always_ff @(posedge clk)
    begin
        if (pole_we)
        begin
            pole_mem[pole_waddr] <= {npl, nph};
        end
        if (pole_rd_en)
        begin
            pole_rd_reg <= pole_mem[pole_raddr];
        end
        if (dly_we)
        begin
            dly_mem[ch_reg] <= {dly_cur[2*SB-1:0], smp_reg};
        end
        if (dly_rd_en)
        begin
            dly_rd_reg <= dly_mem[channel_index];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            smp_reg <= sample_in;
            ch_reg  <= channel_index;
            xl_reg  <= PB'(x_in);
            xh_reg  <= PB'(x_in);
        end
        else if (state_reg == S_MUL && done_a && done_b)
        begin
            xl_reg <= npl;
            xh_reg <= nph;
        end
        if (state_reg == S_GMUL && done_a && done_b)
        begin
            sum_reg <= prod_a + prod_b;
        end
        else if (state_reg == S_MID && done_a)
        begin
            sum_reg <= sum_reg + prod_a;
        end
        if (state_reg == S_FIN && out_free)
        begin
            sample_out_reg  <= bad_reg ? '0 : res;
            channel_out_reg <= ch_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign channel_out = channel_out_reg;
    assign cfg_ready   = 1'b1;

endmodule

// File: design/teq_check.sv
// Port-level checker for three_band_equalizer_core, attached by bind.
// Depends on nothing beyond the top level's ports.
module teq_check #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 16
) (
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      in_valid,
    input logic                                      in_stall,
    input logic                                      out_valid,
    input logic                                      out_stall,
    input logic signed [SAMPLE_BITS-1:0]             sample_out,
    input logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] channel_out
);
    localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic       in_acc, out_acc;
    logic [1:0] pend_reg;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("input accepted on back-to-back cycles");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result shown with no item outstanding");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two items outstanding");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(channel_out))
        else $error("stalled result changed");

    a_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ({1'b0, channel_out} >= (CH_BITS + 1)'(CHANNELS)) |-> sample_out == '0)
        else $error("unknown channel gave a nonzero sample");

endmodule

bind three_band_equalizer_core teq_check #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_teq_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out),
    .channel_out (channel_out)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for three_band_equalizer_core: directed and random samples,
// register sweeps and output hold-off. Depends on teq_pkg and the core.
module tb_top;

    localparam int NUM_CH         = 2;
    localparam int SBITS          = 16;
    localparam int CH_BITS        = 1;
    localparam int IDX_BITS       = teq_pkg::CFG_INDEX_BITS;
    localparam int DATA_BITS      = teq_pkg::CFG_DATA_BITS;
    localparam int OUT_SHIFT      = 30 - SBITS;     // Q.29 sum down to Q1.15
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 40;
    localparam int COEFF_TWO      = 131072;         // 2.0 in Q2.16
    localparam int CFG_MAX        = (1 << teq_pkg::CFG_DATA_BITS) - 1;
    localparam longint POLE_HI    = (longint'(1) <<< (teq_pkg::POLE_BITS - 1)) - 1;
    localparam longint POLE_LO    = -(longint'(1) <<< (teq_pkg::POLE_BITS - 1));
    localparam longint OUT_HI     = (longint'(1) <<< (SBITS - 1)) - 1;
    localparam longint OUT_LO     = -(longint'(1) <<< (SBITS - 1));
    localparam logic signed [SBITS-1:0] FULL_POS = {1'b0, {(SBITS-1){1'b1}}};
    localparam logic signed [SBITS-1:0] FULL_NEG = {1'b1, {(SBITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SBITS-1:0] smp;
        logic [CH_BITS-1:0]      ch;
    } eq_sample_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_stall;
    logic signed [SBITS-1:0]                sample_in;
    logic [CH_BITS-1:0]                     channel_index;
    logic                                   out_valid;
    logic                                   out_stall;
    logic signed [SBITS-1:0]                sample_out;
    logic [CH_BITS-1:0]                     channel_out;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    logic [teq_pkg::CFG_INDEX_BITS-1:0]     cfg_index;
    logic [teq_pkg::CFG_DATA_BITS-1:0]      cfg_data;

    // predictor copy of registers and filter state
    logic [teq_pkg::COEFF_BITS-1:0]         low_coeff_q;
    logic [teq_pkg::COEFF_BITS-1:0]         high_coeff_q;
    logic [teq_pkg::GAIN_BITS-1:0]          low_gain_q;
    logic [teq_pkg::GAIN_BITS-1:0]          mid_gain_q;
    logic [teq_pkg::GAIN_BITS-1:0]          high_gain_q;
    logic signed [teq_pkg::POLE_BITS-1:0]   low_pole [NUM_CH][teq_pkg::STAGES];
    logic signed [teq_pkg::POLE_BITS-1:0]   high_pole [NUM_CH][teq_pkg::STAGES];
    logic signed [SBITS-1:0]                sample_hist [NUM_CH][teq_pkg::DELAY_TAPS];

    eq_sample_t pending_out[$];
    int mismatches;
    int items_sent;
    int results_checked;
    int cfg_writes;
    int in_idle_pct;
    int out_stall_pct;
    int quiet_cycles;
    bit hold_req;

    three_band_equalizer_core #(
        .CHANNELS    (NUM_CH),
        .SAMPLE_BITS (SBITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_in     (sample_in),
        .channel_index (channel_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .channel_out   (channel_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_eq_state();
        int c;
        int s;
        low_coeff_q  = teq_pkg::LOW_COEFF_RST;
        high_coeff_q = teq_pkg::HIGH_COEFF_RST;
        low_gain_q   = teq_pkg::GAIN_RST;
        mid_gain_q   = teq_pkg::GAIN_RST;
        high_gain_q  = teq_pkg::GAIN_RST;
        for (c = 0; c < NUM_CH; c++)
        begin
            for (s = 0; s < teq_pkg::STAGES; s++)
            begin
                low_pole[c][s]  = '0;
                high_pole[c][s] = '0;
            end
            for (s = 0; s < teq_pkg::DELAY_TAPS; s++)
                sample_hist[c][s] = '0;
        end
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        clamp_to = (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Four one-pole stages; each pole is rounded and clamped to 24 bits.
    function automatic longint run_cascade(input bit high_side, input int c, input longint x);
        longint k;
        longint p;
        longint np;
        int     s;
        k = high_side ? longint'(high_coeff_q) : longint'(low_coeff_q);
        for (s = 0; s < teq_pkg::STAGES; s++)
        begin
            p  = high_side ? longint'(high_pole[c][s]) : longint'(low_pole[c][s]);
            np = clamp_to(p + ((k * (x - p) + 32768) >>> teq_pkg::RND_SHIFT),
                          POLE_LO, POLE_HI);
            if (high_side)
                high_pole[c][s] = np[teq_pkg::POLE_BITS-1:0];
            else
                low_pole[c][s] = np[teq_pkg::POLE_BITS-1:0];
            x = np;
        end
        run_cascade = x;
    endfunction

    function automatic eq_sample_t eq_predict(input logic signed [SBITS-1:0] smp,
                                              input logic [CH_BITS-1:0] ch);
        longint x;
        longint d;
        longint lo_band;
        longint hi_band;
        longint mid_band;
        longint acc;
        longint r;
        int     c;
        int     t;
        c        = ch;
        x        = longint'(smp) * 2;
        d        = longint'(sample_hist[c][teq_pkg::DELAY_TAPS-1]) * 2;
        lo_band  = run_cascade(1'b0, c, x);
        hi_band  = d - run_cascade(1'b1, c, x);
        mid_band = d - (hi_band + lo_band);
        acc = lo_band * longint'(low_gain_q) + mid_band * longint'(mid_gain_q)
            + hi_band * longint'(high_gain_q);
        for (t = teq_pkg::DELAY_TAPS - 1; t > 0; t--)
            sample_hist[c][t] = sample_hist[c][t-1];
        sample_hist[c][0] = smp;
        r = clamp_to((acc + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT, OUT_LO, OUT_HI);
        eq_predict.smp = r[SBITS-1:0];
        eq_predict.ch  = ch;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_out.size() == 0)
            begin
                report_mismatch("unexpected sample_out", longint'(sample_out), 0);
            end
            else
            begin
                if (sample_out !== pending_out[0].smp)
                    report_mismatch("sample_out", longint'(sample_out),
                                    longint'(pending_out[0].smp));
                if (channel_out !== pending_out[0].ch)
                    report_mismatch("channel_out", longint'(channel_out),
                                    longint'(pending_out[0].ch));
                void'(pending_out.pop_front());
                results_checked++;
            end
        end
    end

    // output side: random stalls, or one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays high from one item to the next unless an idle gap is drawn
    task automatic send_sample(input int smp, input int ch);
        logic signed [SBITS-1:0] smp_bits;
        logic [CH_BITS-1:0]      ch_bits;
        smp_bits = SBITS'(smp);
        ch_bits  = CH_BITS'(ch);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
        end
        in_valid      <= 1'b1;
        sample_in     <= smp_bits;
        channel_index <= ch_bits;
        do @(posedge clk); while (in_stall);
        pending_out.push_back(eq_predict(smp_bits, ch_bits));
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= IDX_BITS'(idx);
        cfg_data  <= DATA_BITS'(data);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            teq_pkg::REG_LOW_COEFF:  low_coeff_q  = data[teq_pkg::COEFF_BITS-1:0];
            teq_pkg::REG_HIGH_COEFF: high_coeff_q = data[teq_pkg::COEFF_BITS-1:0];
            teq_pkg::REG_LOW_GAIN:   low_gain_q   = data[teq_pkg::GAIN_BITS-1:0];
            teq_pkg::REG_MID_GAIN:   mid_gain_q   = data[teq_pkg::GAIN_BITS-1:0];
            teq_pkg::REG_HIGH_GAIN:  high_gain_q  = data[teq_pkg::GAIN_BITS-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic program_eq(input int lc, input int hc, input int lg, input int mg,
                              input int hg);
        drain_results();
        write_reg(teq_pkg::REG_LOW_COEFF, lc);
        write_reg(teq_pkg::REG_HIGH_COEFF, hc);
        write_reg(teq_pkg::REG_LOW_GAIN, lg);
        write_reg(teq_pkg::REG_MID_GAIN, mg);
        write_reg(teq_pkg::REG_HIGH_GAIN, hg);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SBITS-1:0] random_sample();
        case ($urandom_range(7))
            0:       random_sample = FULL_POS;
            1:       random_sample = FULL_NEG;
            2:       random_sample = SBITS'($urandom_range(511) - 256);
            default: random_sample = SBITS'($urandom());
        endcase
    endfunction

    function automatic int random_coeff();
        case ($urandom_range(7))
            0:       random_coeff = 0;
            1:       random_coeff = COEFF_TWO;
            2:       random_coeff = $urandom_range(CFG_MAX, COEFF_TWO + 1);
            default: random_coeff = $urandom_range(COEFF_TWO);
        endcase
    endfunction

    // upper data bits are dropped by the 16-bit gain registers
    function automatic int random_gain();
        case ($urandom_range(5))
            0:       random_gain = 0;
            1:       random_gain = CFG_MAX;
            2:       random_gain = $urandom_range(CFG_MAX);
            default: random_gain = $urandom_range(2 * teq_pkg::GAIN_RST);
        endcase
    endfunction

    task automatic test_register_defaults();
        send_sample(FULL_POS, 0);
        send_sample(FULL_POS, 0);
        send_sample(FULL_NEG, 1);
        send_sample(FULL_NEG, 1);
        send_sample(0, 0);
        send_sample(-1, 1);
        send_sample(1, 0);
        send_sample(FULL_NEG, 0);
        send_sample(FULL_POS, 1);
    endtask

    task automatic test_band_extremes();
        int idx;
        // frozen poles, max gains: output clips
        program_eq(0, 0, CFG_MAX, CFG_MAX, CFG_MAX);
        send_sample(FULL_POS, 0);
        send_sample(FULL_NEG, 1);
        send_sample(FULL_NEG, 0);
        // coefficient 2.0 on both cascades
        program_eq(COEFF_TWO, COEFF_TWO, teq_pkg::GAIN_RST, teq_pkg::GAIN_RST,
                   teq_pkg::GAIN_RST);
        send_sample(FULL_POS, 1);
        send_sample(FULL_NEG, 1);
        send_sample(FULL_POS, 1);
        // out-of-range coefficient: poles run away into saturation, muted output
        program_eq(CFG_MAX, CFG_MAX, 0, 0, 0);
        repeat (3)
        begin
            send_sample(FULL_POS, 0);
            send_sample(FULL_NEG, 0);
        end
        // unused register indexes must not disturb anything
        drain_results();
        for (idx = teq_pkg::REG_HIGH_GAIN + 1; idx < (1 << teq_pkg::CFG_INDEX_BITS); idx++)
            write_reg(idx, $urandom_range(CFG_MAX));
        cfg_valid <= 1'b0;
        send_sample(FULL_POS, 1);
        send_sample(FULL_NEG, 0);
        send_sample(0, 1);
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        int ph;
        int n;
        for (ph = 0; ph < phases; ph++)
        begin
            program_eq(random_coeff(), random_coeff(), random_gain(), random_gain(),
                       random_gain());
            for (n = 0; n < per_phase; n++)
                send_sample(random_sample(), $urandom_range(1));
        end
    endtask

    // output held off long enough that the core backs up onto its input
    task automatic test_output_hold();
        int n;
        program_eq($urandom_range(COEFF_TWO), $urandom_range(COEFF_TWO), teq_pkg::GAIN_RST,
                   $urandom_range(2 * teq_pkg::GAIN_RST), teq_pkg::GAIN_RST);
        hold_req = 1'b1;
        for (n = 0; n < 16; n++)
            send_sample(random_sample(), $urandom_range(1));
        drain_results();
    endtask

    task automatic test_back_to_back();
        int n;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        for (n = 0; n < 150; n++)
            send_sample(random_sample(), $urandom_range(1));
        drain_results();
        in_idle_pct   = 19;
        out_stall_pct = 19;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        sample_in     = '0;
        channel_index = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_idle_pct   = 19;
        out_stall_pct = 19;
        hold_req      = 1'b0;
        quiet_cycles  = 0;
        mismatches    = 0;
        clear_eq_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_register_defaults();
        test_band_extremes();
        test_random_settings(3, 180);
        test_output_hold();
        test_back_to_back();
        test_random_settings(3, 180);
        program_eq(teq_pkg::LOW_COEFF_RST, teq_pkg::HIGH_COEFF_RST, teq_pkg::GAIN_RST,
                   teq_pkg::GAIN_RST, teq_pkg::GAIN_RST);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("summary: %0d samples on both channels, %0d results checked, %0d reg writes",
                 items_sent, results_checked, cfg_writes);
        $display("summary: coefficients 0 to max, gains 0 to max, long output hold, %0d errors",
                 mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
